// ----- rtl/tcpu_pkg.sv -----
// tcpu_pkg: instruction field codes, flag positions and shared types for
// the tiny 8-bit CPU core. No dependencies.
package tcpu_pkg;

   // Item codes
   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_STEP = 1'b1;

   // Condition field, bits 7:6
   localparam logic [1:0] COND_ALWAYS = 2'd0;
   localparam logic [1:0] COND_Z      = 2'd1;
   localparam logic [1:0] COND_O      = 2'd2;
   localparam logic [1:0] COND_E      = 2'd3;

   // Class field, bits 5:4
   localparam logic [1:0] CLS_MOVE = 2'd0;
   localparam logic [1:0] CLS_ALU  = 2'd1;
   localparam logic [1:0] CLS_LDLO = 2'd2;
   localparam logic [1:0] CLS_LDHI = 2'd3;

   // Move class functions
   localparam logic [3:0] MV_RA   = 4'd0;
   localparam logic [3:0] MV_SA   = 4'd1;
   localparam logic [3:0] MV_RI   = 4'd2;
   localparam logic [3:0] MV_SI   = 4'd3;
   localparam logic [3:0] MV_RX   = 4'd4;
   localparam logic [3:0] MV_SX   = 4'd5;
   localparam logic [3:0] MV_RY   = 4'd6;
   localparam logic [3:0] MV_SY   = 4'd7;
   localparam logic [3:0] MV_RM   = 4'd8;
   localparam logic [3:0] MV_SM   = 4'd9;
   localparam logic [3:0] MV_RP   = 4'd10;
   localparam logic [3:0] MV_SP   = 4'd11;
   localparam logic [3:0] MV_CLR  = 4'd12;
   localparam logic [3:0] MV_SETE = 4'd13;
   localparam logic [3:0] MV_CLRE = 4'd14;
   localparam logic [3:0] MV_CLZO = 4'd15;

   // ALU functions
   localparam logic [3:0] ALU_ADD  = 4'd0;
   localparam logic [3:0] ALU_ADC  = 4'd1;
   localparam logic [3:0] ALU_SB   = 4'd2;
   localparam logic [3:0] ALU_SUB  = 4'd3;
   localparam logic [3:0] ALU_NOTX = 4'd4;
   localparam logic [3:0] ALU_X    = 4'd5;
   localparam logic [3:0] ALU_AND  = 4'd6;
   localparam logic [3:0] ALU_NAND = 4'd7;
   localparam logic [3:0] ALU_OR   = 4'd8;
   localparam logic [3:0] ALU_NOR  = 4'd9;
   localparam logic [3:0] ALU_XOR  = 4'd10;
   localparam logic [3:0] ALU_XNOR = 4'd11;
   localparam logic [3:0] ALU_SHR  = 4'd12;
   localparam logic [3:0] ALU_SHRH = 4'd13;
   localparam logic [3:0] ALU_SHL  = 4'd14;
   localparam logic [3:0] ALU_SHLL = 4'd15;

   // Flag bit positions within the Z/O/E vector
   localparam int FLAG_Z = 2;
   localparam int FLAG_O = 1;
   localparam int FLAG_E = 0;

   localparam int MEM_DEPTH = 256;

   typedef struct packed {
      logic [7:0] res;
      logic       ov;
   } alu_out_type;

endpackage

// ----- rtl/tcpu_alu.sv -----
// tcpu_alu: 16-function ALU on X and Y with overflow flag.
// Depends on tcpu_pkg.
module tcpu_alu import tcpu_pkg::*; (
   input  logic [7:0]  x,
   input  logic [7:0]  y,
   input  logic [3:0]  fn,
   output alu_out_type result
);

   logic [8:0] sum;
   logic [7:0] y_op;
   logic [7:0] res;
   logic       ov;

   // subtract forms use the inverted operand, odd codes add one
   assign y_op = fn[1] ? ~y : y;
   assign sum  = {1'b0, x} + {1'b0, y_op} + {8'd0, fn[0]};

   always_comb begin
      res = 8'd0;
      ov  = 1'b0;
      case (fn)
         ALU_ADD, ALU_ADC, ALU_SB, ALU_SUB: begin
            res = sum[7:0];
            ov  = sum[8];
         end
         ALU_NOTX: res = ~x;
         ALU_X:    res = x;
         ALU_AND:  res = x & y;
         ALU_NAND: res = ~(x & y);
         ALU_OR:   res = x | y;
         ALU_NOR:  res = ~(x | y);
         ALU_XOR:  res = x ^ y;
         ALU_XNOR: res = ~(x ^ y);
         ALU_SHR:  res = {1'b0, x[7:1]};
         ALU_SHRH: begin
            res = {1'b1, x[7:1]};
            ov  = (x != 8'd0);
         end
         ALU_SHL:  res = {x[6:0], 1'b0};
         ALU_SHLL: begin
            res = {x[6:0], 1'b1};
            ov  = x[7];
         end
         default: res = 8'd0;
      endcase
      // logic and plain shift forms flag an all-ones result
      if (fn inside {[ALU_NOTX:ALU_SHR], ALU_SHL}) begin
         ov = (res == 8'hff);
      end
   end

   assign result = '{res: res, ov: ov};

endmodule

// ----- rtl/tiny_8bit_cpu_core.sv -----
// tiny_8bit_cpu_core: top level of the 8-bit accumulator CPU.
// Depends on tcpu_pkg and tcpu_alu.
//
// Usage
//  - Request channel (req_*): one transfer is either a load (req_op = 0),
//    which writes req_load_data to memory at req_load_addr, or a step
//    (req_op = 1), which executes the instruction at the program counter.
//    req_port_in supplies the byte taken by a port read in that step.
//  - Response channel (rsp_*): exactly one transfer per request, in order,
//    carrying the halt state after the item and any port access it made.
//  - Path: a request is held in an input register, executed in one
//    combinational pass and lands in the output register; its response
//    can transfer from there when rsp_stall is low.
//  - Throughput: one item per cycle while rsp_stall is low. Fetch (mem[I])
//    and data (mem[A]) are read into registers one item ahead, at the next
//    I and A, with a same-cycle memory write bypassed into them.
//  - Stall: with rsp_stall high and a response waiting, one further request
//    is taken into the input register; after that req_stall is raised.
//  - Reset: synchronous, active high. Registers, flags and the halt state
//    clear; memory reads as zero through per-byte valid bits until written.
//  - Once the program counter steps past 255 the core halts; steps then
//    change nothing, loads still write memory.
module tiny_8bit_cpu_core import tcpu_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   // request channel
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_op,
   input  logic [7:0] req_load_addr,
   input  logic [7:0] req_load_data,
   input  logic [7:0] req_port_in,
   // response channel
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_halted_flag,
   output logic       rsp_port_write,
   output logic       rsp_port_read,
   output logic [7:0] rsp_port_addr,
   output logic [7:0] rsp_port_data
);

   // ---------------------------------------------------------------
   // Input register stage
   // ---------------------------------------------------------------
   logic       s1_valid_ff, s1_valid_in;
   logic       s1_op_ff;
   logic [7:0] s1_addr_ff, s1_data_ff, s1_port_ff;

   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;   // output register can take a result this cycle
   logic       advance;    // input register item executes this cycle
   logic       req_take;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = s1_valid_ff && out_free;
   assign req_stall = s1_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_take) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_op_ff   <= req_op;
         s1_addr_ff <= req_load_addr;
         s1_data_ff <= req_load_data;
         s1_port_ff <= req_port_in;
      end
   end

   // ---------------------------------------------------------------
   // Architectural state
   // ---------------------------------------------------------------
   logic [7:0] mem_ff [MEM_DEPTH];
   logic [MEM_DEPTH-1:0] mem_vld_ff;   // unwritten bytes read as zero

   logic [7:0] r_ff, r_in;
   logic [7:0] pc_ff, pc_in;
   logic [7:0] a_ff, a_in;
   logic [7:0] x_ff, x_in;
   logic [7:0] y_ff, y_in;
   logic [2:0] flags_ff, flags_in;
   logic       halt_ff, halt_in;

   // mem[I] and mem[A], read one item ahead
   logic [7:0] inst_ff, mdata_ff;

   logic       mem_we;
   logic [7:0] mem_waddr, mem_wdata;

   logic [7:0] inst, mem_data;
   logic [1:0] cond, cls;
   logic [3:0] lo;
   logic       run;

   logic       pw, pr;
   logic [7:0] paddr, pdata;

   alu_out_type alu_res;

   assign inst     = inst_ff;
   assign mem_data = mdata_ff;
   assign cond     = inst[7:6];
   assign cls      = inst[5:4];
   assign lo       = inst[3:0];

   tcpu_alu u_alu (
      .x      (x_ff),
      .y      (y_ff),
      .fn     (lo),
      .result (alu_res)
   );

   always_comb begin
      case (cond)
         COND_ALWAYS: run = 1'b1;
         COND_Z:      run = flags_ff[FLAG_Z];
         COND_O:      run = flags_ff[FLAG_O];
         COND_E:      run = flags_ff[FLAG_E];
         default:     run = 1'b0;
      endcase
   end

   // single execution pass for the item in the input register
   always_comb begin
      r_in      = r_ff;
      pc_in     = pc_ff;
      a_in      = a_ff;
      x_in      = x_ff;
      y_in      = y_ff;
      flags_in  = flags_ff;
      halt_in   = halt_ff;
      mem_we    = 1'b0;
      mem_waddr = s1_addr_ff;
      mem_wdata = s1_data_ff;
      pw        = 1'b0;
      pr        = 1'b0;
      paddr     = 8'd0;
      pdata     = 8'd0;

      if (s1_op_ff == OP_LOAD) begin
         mem_we = 1'b1;
      end else if (!halt_ff) begin
         if (run) begin
            case (cls)
               CLS_MOVE: begin
                  case (lo)
                     MV_RA:   r_in = a_ff;
                     MV_SA:   a_in = r_ff;
                     MV_RI:   r_in = pc_ff;
                     MV_SI:   r_in = r_ff;   // jump handled below
                     MV_RX:   r_in = x_ff;
                     MV_SX:   x_in = r_ff;
                     MV_RY:   r_in = y_ff;
                     MV_SY:   y_in = r_ff;
                     MV_RM:   r_in = mem_data;
                     MV_SM: begin
                        mem_we    = 1'b1;
                        mem_waddr = a_ff;
                        mem_wdata = r_ff;
                     end
                     MV_RP: begin
                        pr    = 1'b1;
                        paddr = a_ff;
                        r_in  = s1_port_ff;
                     end
                     MV_SP: begin
                        pw    = 1'b1;
                        paddr = a_ff;
                        pdata = r_ff;
                     end
                     MV_CLR:  flags_in = 3'b000;
                     MV_SETE: flags_in[FLAG_E] = 1'b1;
                     MV_CLRE: flags_in[FLAG_E] = 1'b0;
                     MV_CLZO: begin
                        flags_in[FLAG_Z] = 1'b0;
                        flags_in[FLAG_O] = 1'b0;
                     end
                     default: r_in = r_ff;
                  endcase
               end
               CLS_ALU: begin
                  r_in             = alu_res.res;
                  flags_in[FLAG_Z] = (alu_res.res == 8'd0);
                  flags_in[FLAG_O] = alu_res.ov;
               end
               CLS_LDLO: r_in = {r_ff[7:4], lo};
               CLS_LDHI: r_in = {lo, r_ff[3:0]};
               default:  r_in = r_ff;
            endcase
         end

         // jump does not increment, so it never halts
         if (run && cls == CLS_MOVE && lo == MV_SI) begin
            pc_in = r_ff;
         end else begin
            pc_in = pc_ff + 8'd1;
            if (pc_ff == 8'hff) begin
               halt_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         r_ff     <= 8'd0;
         pc_ff    <= 8'd0;
         a_ff     <= 8'd0;
         x_ff     <= 8'd0;
         y_ff     <= 8'd0;
         flags_ff <= 3'd0;
         halt_ff  <= 1'b0;
      end else if (advance) begin
         r_ff     <= r_in;
         pc_ff    <= pc_in;
         a_ff     <= a_in;
         x_ff     <= x_in;
         y_ff     <= y_in;
         flags_ff <= flags_in;
         halt_ff  <= halt_in;
      end
   end

   // memory contents, no reset; valid bits stand in for the zero fill
   always_ff @(posedge clock) begin
      if (advance && mem_we) begin
         mem_ff[mem_waddr] <= mem_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mem_vld_ff <= '0;
      end else if (advance && mem_we) begin
         mem_vld_ff[mem_waddr] <= 1'b1;
      end
   end

   // registered reads at the next I and A; a write in the same cycle
   // to the same byte is passed straight through
   always_ff @(posedge clock) begin
      if (reset) begin
         inst_ff  <= 8'd0;
         mdata_ff <= 8'd0;
      end else if (advance) begin
         if (mem_we && mem_waddr == pc_in) begin
            inst_ff <= mem_wdata;
         end else if (mem_vld_ff[pc_in]) begin
            inst_ff <= mem_ff[pc_in];
         end else begin
            inst_ff <= 8'd0;
         end
         if (mem_we && mem_waddr == a_in) begin
            mdata_ff <= mem_wdata;
         end else if (mem_vld_ff[a_in]) begin
            mdata_ff <= mem_ff[a_in];
         end else begin
            mdata_ff <= 8'd0;
         end
      end
   end

   // ---------------------------------------------------------------
   // Output register
   // ---------------------------------------------------------------
   logic       halted_ff, pw_ff, pr_ff;
   logic [7:0] paddr_ff, pdata_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         halted_ff <= halt_in;
         pw_ff     <= pw;
         pr_ff     <= pr;
         paddr_ff  <= paddr;
         pdata_ff  <= pdata;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_halted_flag = halted_ff;
   assign rsp_port_write  = pw_ff;
   assign rsp_port_read   = pr_ff;
   assign rsp_port_addr   = paddr_ff;
   assign rsp_port_data   = pdata_ff;

endmodule
